FILE: rtl/particle_impact_erosion_accumulator_core_defines.svh
// Assertion macros for the erosion accumulator core.
`ifndef PARTICLE_IMPACT_EROSION_ACCUMULATOR_CORE_DEFINES_SVH
`define PARTICLE_IMPACT_EROSION_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PIEA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define PIEA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define PIEA_ASSERT(lbl, prop)
`define PIEA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/piea_pkg.sv
// Shared constants for the erosion accumulator core.
package piea_pkg;

  localparam logic [1:0] OP_IMPACT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] REG_MASK  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_K     = 2'd2;

  localparam logic [47:0] WEAR_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] SIX_K     = 16'd24576;
  localparam logic [31:0] SCALE_RST = 32'd65536;
  localparam logic [15:0] K_RST     = 16'd8192;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 68;

endpackage

FILE: rtl/particle_impact_erosion_accumulator_core.sv
// Finnie erosion accumulator: impact wear math and per-face wear store.
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata fields, s_tuser op
// m_*       out  m_tvalid/m_tready   m_tdata slot, total, applied, saturated
// apb       in   psel/penable        paddr, pwdata, prdata
//
// An applied impact is dominated by a 24-step square root and a 68-step restoring
// divider, with a single shared 33x33 multiplier. Reads and disabled impacts skip the
// wear math, impacts moving away stop after the dot product; a clear sweeps all slots.
// After reset a clearing pass over all FACE_SLOTS slots runs before s_tready rises.
// A result waiting on m_tready holds the core in its final state.
`include "particle_impact_erosion_accumulator_core_defines.svh"

module particle_impact_erosion_accumulator_core #(
  parameter int FACE_SLOTS  = 1024,
  parameter int PATCH_COUNT = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // patch_id, face_slot, rel_vel_x, rel_vel_y, rel_vel_z,
  // normal_x, normal_y, normal_z, parcel_mass
  input  logic [167:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot_out, erosion_total, applied, saturated, zero fill
  output logic [63:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int AW = $clog2(FACE_SLOTS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_PRE, ST_SQRT, ST_MID, ST_DIV, ST_FIN
  } state_t;

  state_t state;
  logic [6:0] cnt;
  logic post;

  logic [63:0] mask;
  logic [31:0] scale;
  logic [15:0] kc;

  logic [1:0]  opr;
  logic [9:0]  slot;
  logic [9:0]  slot_q;
  logic signed [23:0] vx, vy, vz;
  logic signed [15:0] nx, ny, nz;
  logic [31:0] mass;
  logic        good;
  logic        ok_q;
  logic        apply;
  logic        clr_out;
  logic [47:0] cur_total;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] clr_addr;

  logic [41:0] d_acc;
  logic [48:0] u2;
  logic [51:0] dd;
  logic [47:0] t2;
  logic [47:0] sq_x;
  logic [48:0] sq_r;
  logic [47:0] sq_bit;
  logic [39:0] kt;
  logic [49:0] dt;
  logic        regime1;
  logic [63:0] tk;
  logic [67:0] div_n;
  logic [15:0] div_r;
  logic [15:0] div_d;
  logic [51:0] g;
  logic [83:0] p1;
  logic [115:0] acc;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  logic [47:0] mem [FACE_SLOTS];
  logic [47:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [47:0]   mem_wdata;

  logic s_fire, out_free;
  logic in_ok, in_en;
  logic [25:0] d12;
  logic [23:0] tval;
  logic [51:0] t2_diff;
  logic [40:0] d6k;
  logic [16:0] div_trial;
  logic [67:0] add68;
  logic [47:0] wear;
  logic [48:0] sum49;
  logic [47:0] total_new;
  logic [47:0] out_total;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_ok = (32'(s_tdata[15:6]) < FACE_SLOTS);
  assign in_en = (32'(s_tdata[5:0]) < PATCH_COUNT) && mask[s_tdata[5:0]];

  assign d12  = d_acc[39:14];
  assign tval = sq_r[23:0];
  assign t2_diff = ({3'b0, u2} > prod_q[51:0]) ? ({3'b0, u2} - prod_q[51:0]) : 52'd0;
  assign d6k  = {1'b0, d12, 14'b0} + {2'b0, d12, 13'b0};
  assign div_trial = {div_r, div_n[67]};
  assign add68 = 68'({dt, 1'b0});
  assign wear = (acc[115:88] != 28'd0) ? piea_pkg::WEAR_MAX : acc[87:40];
  assign sum49 = {1'b0, cur_total} + {1'b0, wear};
  assign total_new = !apply ? cur_total :
                     (sum49 > {1'b0, piea_pkg::WEAR_MAX}) ? piea_pkg::WEAR_MAX : sum49[47:0];
  assign out_total = total_new;

  always_comb begin
    case (paddr[4:3])
      piea_pkg::REG_MASK:  prdata = mask;
      piea_pkg::REG_SCALE: prdata = {32'b0, scale};
      piea_pkg::REG_K:     prdata = {48'b0, kc};
      default:             prdata = 64'b0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PRE: begin
        case (cnt)
          7'd0: begin mul_a = 33'(vx); mul_b = 33'(nx); end
          7'd1: begin mul_a = 33'(vy); mul_b = 33'(ny); end
          7'd2: begin mul_a = 33'(vz); mul_b = 33'(nz); end
          7'd3: begin mul_a = 33'(vx); mul_b = 33'(vx); end
          7'd4: begin mul_a = 33'(vy); mul_b = 33'(vy); end
          7'd5: begin mul_a = 33'(vz); mul_b = 33'(vz); end
          7'd6: begin mul_a = $signed(33'(d12)); mul_b = $signed(33'(d12)); end
          default: ;
        endcase
      end
      ST_MID: begin
        case (cnt)
          7'd0: begin mul_a = $signed(33'(kc)); mul_b = $signed(33'(tval)); end
          7'd1: begin mul_a = $signed(33'(d12)); mul_b = $signed(33'(tval)); end
          7'd2: begin mul_a = $signed(33'(t2[31:0])); mul_b = $signed(33'(kc)); end
          7'd3: begin mul_a = $signed(33'(t2[47:32])); mul_b = $signed(33'(kc)); end
          default: ;
        endcase
      end
      ST_FIN: begin
        if (post) begin
          case (cnt)
            7'd1: begin mul_a = $signed(33'(g[31:0])); mul_b = $signed(33'(scale)); end
            7'd2: begin mul_a = $signed(33'(g[51:32])); mul_b = $signed(33'(scale)); end
            7'd4: begin mul_a = $signed(33'(p1[31:0])); mul_b = $signed(33'(mass)); end
            7'd5: begin mul_a = $signed(33'(p1[63:32])); mul_b = $signed(33'(mass)); end
            7'd6: begin mul_a = $signed(33'(p1[83:64])); mul_b = $signed(33'(mass)); end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign rd_addr   = (state == ST_IDLE) ? AW'(s_tdata[15:6]) : addr_q;
  assign mem_we    = (state == ST_CLEAR) || (state == ST_FIN && !post && out_free && apply);
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : addr_q;
  assign mem_wdata = (state == ST_CLEAR) ? 48'd0 : total_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      post     <= 1'b0;
      clr_addr <= '0;
      clr_out  <= 1'b0;
      m_tvalid <= 1'b0;
      mask     <= 64'd0;
      scale    <= piea_pkg::SCALE_RST;
      kc       <= piea_pkg::K_RST;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:3])
          piea_pkg::REG_MASK:  mask  <= pwdata;
          piea_pkg::REG_SCALE: scale <= pwdata[31:0];
          piea_pkg::REG_K:     kc    <= pwdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(FACE_SLOTS - 1)) begin
            clr_addr <= '0;
            if (clr_out) begin
              clr_out <= 1'b0;
              state   <= ST_FIN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            opr    <= s_tuser;
            slot   <= s_tdata[15:6];
            addr_q <= AW'(s_tdata[15:6]);
            vx     <= s_tdata[39:16];
            vy     <= s_tdata[63:40];
            vz     <= s_tdata[87:64];
            nx     <= s_tdata[103:88];
            ny     <= s_tdata[119:104];
            nz     <= s_tdata[135:120];
            mass   <= s_tdata[167:136];
            ok_q   <= in_ok;
            good   <= (s_tuser == piea_pkg::OP_IMPACT) && in_ok && in_en;
            apply  <= 1'b0;
            post   <= 1'b0;
            state  <= ST_RD;
          end
        end
        ST_RD: begin
          cur_total <= ok_q ? rd_data : 48'd0;
          slot_q    <= slot;
          cnt       <= '0;
          case (opr)
            piea_pkg::OP_IMPACT: state <= good ? ST_PRE : ST_FIN;
            piea_pkg::OP_READ:   state <= ST_FIN;
            piea_pkg::OP_CLEAR: begin
              cur_total <= 48'd0;
              slot_q    <= 10'd0;
              clr_out   <= 1'b1;
              state     <= ST_CLEAR;
            end
            default: begin
              cur_total <= 48'd0;
              slot_q    <= 10'd0;
              state     <= ST_FIN;
            end
          endcase
        end
        ST_PRE: begin
          cnt <= cnt + 7'd1;
          case (cnt)
            7'd1: d_acc <= prod_q[41:0];
            7'd2: d_acc <= d_acc + prod_q[41:0];
            7'd3: d_acc <= d_acc + prod_q[41:0];
            7'd4: begin
              u2 <= prod_q[48:0];
              if (d_acc[41]) begin
                state <= ST_FIN;
              end
            end
            7'd5: u2 <= u2 + prod_q[48:0];
            7'd6: u2 <= u2 + prod_q[48:0];
            7'd7: begin
              dd     <= prod_q[51:0];
              t2     <= t2_diff[47:0];
              sq_x   <= t2_diff[47:0];
              sq_r   <= '0;
              sq_bit <= 48'h4000_0000_0000;
              cnt    <= '0;
              state  <= ST_SQRT;
            end
            default: ;
          endcase
        end
        ST_SQRT: begin
          if ({1'b0, sq_x} >= sq_r + {1'b0, sq_bit}) begin
            sq_x <= sq_x - (sq_r[47:0] + sq_bit);
            sq_r <= (sq_r >> 1) + {1'b0, sq_bit};
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 7'd1;
          if (cnt == 7'(piea_pkg::SQRT_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_MID;
          end
        end
        ST_MID: begin
          cnt <= cnt + 7'd1;
          case (cnt)
            7'd1: kt <= prod_q[39:0];
            7'd2: begin
              regime1 <= (d6k < {1'b0, kt});
              dt      <= prod_q[49:0];
            end
            7'd3: tk <= prod_q[63:0];
            7'd4: tk <= tk + {prod_q[31:0], 32'b0};
            7'd5: begin
              if (regime1) begin
                div_n <= {1'b0, dd, 15'b0} - {2'b0, dd, 14'b0} + {3'b0, dd, 13'b0} -
                         {2'b0, dd, 14'b0} + {2'b0, dd, 14'b0};
                div_d <= (kc == 16'd0) ? 16'd1 : kc;
              end else begin
                div_n <= {4'b0, tk};
                div_d <= piea_pkg::SIX_K;
              end
              div_r <= '0;
              cnt   <= '0;
              state <= ST_DIV;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_trial >= {1'b0, div_d}) begin
            div_r <= 16'(div_trial - {1'b0, div_d});
            div_n <= {div_n[66:0], 1'b1};
          end else begin
            div_r <= div_trial[15:0];
            div_n <= {div_n[66:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'(piea_pkg::DIV_STEPS - 1)) begin
            cnt   <= '0;
            post  <= 1'b1;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (post) begin
            cnt <= cnt + 7'd1;
            case (cnt)
              7'd0: begin
                if (regime1) begin
                  g <= (add68 > div_n) ? 52'(add68 - div_n) : 52'd0;
                end else begin
                  g <= div_n[51:0];
                end
              end
              7'd2: p1 <= 84'(prod_q[63:0]);
              7'd3: p1 <= p1 + {prod_q[51:0], 32'b0};
              7'd5: acc <= 116'(prod_q[63:0]);
              7'd6: acc <= acc + 116'({prod_q[63:0], 32'b0});
              7'd7: begin
                acc   <= acc + {prod_q[51:0], 64'b0};
                apply <= 1'b1;
                post  <= 1'b0;
                cnt   <= '0;
              end
              default: ;
            endcase
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, (out_total == piea_pkg::WEAR_MAX), apply, out_total, slot_q};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PIEA_ASSERT(a_we_src, mem_we |-> (state == ST_CLEAR || state == ST_FIN))
  `PIEA_ASSERT(a_sat_flag, m_tvalid |-> (m_tdata[59] == (m_tdata[57:10] == piea_pkg::WEAR_MAX)))
  `PIEA_ASSERT(a_rise_fin, $rose(m_tvalid) |-> $past(state) == ST_FIN)
  `PIEA_ASSERT(a_div_cnt, (state == ST_DIV) |-> (cnt < 7'(piea_pkg::DIV_STEPS)))
  `PIEA_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the Finnie erosion accumulator core.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [1:0]         op;
    logic [5:0]         patch;
    logic [9:0]         slot;
    logic signed [23:0] vx, vy, vz;
    logic signed [15:0] nx, ny, nz;
    logic [31:0]        mass;
  } impact_req_t;

  typedef struct {
    logic [9:0]  slot;
    logic [47:0] total;
    logic        applied;
    logic        sat;
  } wear_rsp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  particle_impact_erosion_accumulator_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  impact_req_t pending_reqs[$];
  wear_rsp_t   expected_rsps[$];
  impact_req_t cur_req;
  impact_req_t next_req;
  logic        req_taken = 1'b0;
  logic        next_valid;
  logic        send_idle = 1'b0;
  logic        recv_idle = 1'b0;
  int          idle_pct = 79;
  int          errors = 0;

  logic [63:0] mdl_mask;
  logic [31:0] mdl_scale;
  logic [15:0] mdl_k;
  logic [47:0] wear_mem[1024];
  logic        wear_valid[1024];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint dot_26(impact_req_t q);
    return longint'(q.nx) * longint'(q.vx) + longint'(q.ny) * longint'(q.vy)
         + longint'(q.nz) * longint'(q.vz);
  endfunction

  function automatic logic [47:0] impact_wear(impact_req_t q);
    longint          ax, ay, az;
    longint unsigned u2, d12, dd, t2, t, k, kd, g, sub, add, six_k;
    logic [127:0]    prod;
    ax = longint'(q.vx); if (ax < 0) ax = -ax;
    ay = longint'(q.vy); if (ay < 0) ay = -ay;
    az = longint'(q.vz); if (az < 0) az = -az;
    u2 = ax * ax + ay * ay + az * az;
    d12 = longint'(dot_26(q)) >>> 14;
    dd = d12 * d12;
    t2 = (u2 > dd) ? u2 - dd : 64'd0;
    t = int_sqrt(t2);
    k = {48'd0, mdl_k};
    six_k = {48'd0, piea_pkg::SIX_K};
    if (six_k * d12 < k * t) begin
      kd = (k != 0) ? k : 64'd1;
      sub = (dd / kd) * six_k + ((dd % kd) * six_k) / kd;
      add = 64'd2 * d12 * t;
      g = (add > sub) ? add - sub : 64'd0;
    end else begin
      g = (t2 / six_k) * k + ((t2 % six_k) * k) / six_k;
    end
    prod = {64'd0, g} * {96'd0, mdl_scale} * {96'd0, q.mass};
    prod = prod >> 40;
    return (prod > {80'd0, piea_pkg::WEAR_MAX}) ? piea_pkg::WEAR_MAX : prod[47:0];
  endfunction

  task automatic predict_wear(impact_req_t q);
    wear_rsp_t       e;
    logic [47:0]     w;
    e.slot = '0; e.total = '0; e.applied = 1'b0;
    if (q.op == piea_pkg::OP_CLEAR) begin
      for (int i = 0; i < 1024; i++) wear_valid[i] = 1'b0;
    end else if (q.op == piea_pkg::OP_READ) begin
      e.slot = q.slot;
      e.total = wear_valid[q.slot] ? wear_mem[q.slot] : 48'd0;
    end else if (q.op == piea_pkg::OP_IMPACT) begin
      e.slot = q.slot;
      e.total = wear_valid[q.slot] ? wear_mem[q.slot] : 48'd0;
      if (mdl_mask[q.patch] && dot_26(q) >= 0) begin
        w = impact_wear(q);
        e.total = (w > piea_pkg::WEAR_MAX - e.total) ? piea_pkg::WEAR_MAX : e.total + w;
        wear_mem[q.slot] = e.total;
        wear_valid[q.slot] = 1'b1;
        e.applied = 1'b1;
      end
    end
    e.sat = (e.total == piea_pkg::WEAR_MAX);
    expected_rsps.push_back(e);
  endtask

  always @(posedge clk) begin
    req_taken = s_tvalid && s_tready;
    if (req_taken) predict_wear(cur_req);
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || req_taken)) begin
      next_valid = 1'b0;
      if (pending_reqs.size() > 0 && !(send_idle && $urandom_range(99) < idle_pct)) begin
        next_req = pending_reqs.pop_front();
        next_valid = 1'b1;
        cur_req <= next_req;
        s_tuser <= next_req.op;
        s_tdata <= {next_req.mass, next_req.nz, next_req.ny, next_req.nx,
                    next_req.vz, next_req.vy, next_req.vx, next_req.slot, next_req.patch};
      end
      s_tvalid <= next_valid;
    end
    m_tready <= !(recv_idle && $urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    wear_rsp_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $realtime, m_tdata);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (m_tdata[9:0] !== e.slot || m_tdata[57:10] !== e.total ||
            m_tdata[58] !== e.applied || m_tdata[59] !== e.sat || m_tdata[63:60] !== 4'd0) begin
          $display("%0t: mismatch expected slot %h total %h applied %b sat %b, actual %h",
                   $realtime, e.slot, e.total, e.applied, e.sat, m_tdata);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == piea_pkg::REG_MASK) mdl_mask = val;
    else if (idx == piea_pkg::REG_SCALE) mdl_scale = val[31:0];
    else if (idx == piea_pkg::REG_K) mdl_k = val[15:0];
  endtask

  task automatic set_config(logic [63:0] m, logic [31:0] s, logic [15:0] k);
    apb_write(piea_pkg::REG_MASK, m);
    apb_write(piea_pkg::REG_SCALE, {32'd0, s});
    apb_write(piea_pkg::REG_K, {48'd0, k});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic impact_req_t mk_req(logic [1:0] op, logic [9:0] slot,
      int vx, int vy, int vz, int nx, int ny, int nz, logic [31:0] mass);
    impact_req_t q;
    q.op = op; q.patch = 6'($urandom_range(63)); q.slot = slot;
    q.vx = 24'(vx); q.vy = 24'(vy); q.vz = 24'(vz);
    q.nx = 16'(nx); q.ny = 16'(ny); q.nz = 16'(nz); q.mass = mass;
    return q;
  endfunction

  function automatic int rand_vel();
    int v;
    v = $signed($urandom_range(24'hFFFFFF, 0) << 8) >>> 8;
    return v >>> $urandom_range(20);
  endfunction

  function automatic impact_req_t rand_req();
    impact_req_t q;
    int          pick, ax;
    pick = $urandom_range(99);
    q.op = (pick < 2) ? piea_pkg::OP_CLEAR : (pick < 15) ? piea_pkg::OP_READ :
           piea_pkg::OP_IMPACT;
    q.patch = 6'($urandom_range(63));
    q.slot = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(15));
    q.vx = 24'(rand_vel()); q.vy = 24'(rand_vel()); q.vz = 24'(rand_vel());
    if ($urandom_range(3) == 0) begin
      q.nx = 16'($urandom_range(32768) - 16384);
      q.ny = 16'($urandom_range(32768) - 16384);
      q.nz = 16'($urandom_range(32768) - 16384);
    end else begin
      ax = $urandom_range(2);
      q.nx = '0; q.ny = '0; q.nz = '0;
      if (ax == 0) q.nx = 16'($urandom_range(1) ? 16384 : -16384);
      else if (ax == 1) q.ny = 16'($urandom_range(1) ? 16384 : -16384);
      else q.nz = 16'($urandom_range(1) ? 16384 : -16384);
    end
    q.mass = $urandom() >> $urandom_range(31);
    return q;
  endfunction

  initial begin
    mdl_mask = '0; mdl_scale = piea_pkg::SCALE_RST; mdl_k = piea_pkg::K_RST;
    for (int i = 0; i < 1024; i++) wear_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd3, 1000, 0, 4096, 0, 0, 16384,
                                  32'd50));
    pending_reqs.push_back(mk_req(piea_pkg::OP_READ, 10'd3, 0, 0, 0, 0, 0, 0, 32'd0));
    wait_drained();
    for (int p = 0; p < 8; p++) begin
      send_idle = (p % 4 == 1) || (p % 4 == 3);
      recv_idle = (p % 4 == 2) || (p % 4 == 3);
      idle_pct = (p % 4 == 3) ? 33 : 79;
      case (p)
        0: set_config('1, piea_pkg::SCALE_RST, piea_pkg::K_RST);
        1: set_config({$urandom(), $urandom()}, 32'hFFFF_FFFF, 16'hFFFF);
        2: set_config('1, 32'd0, 16'd1);
        3: set_config({$urandom(), $urandom()}, $urandom(), 16'($urandom()));
        4: set_config('1, $urandom() >> 16, 16'd0);
        5: set_config({$urandom(), $urandom()}, piea_pkg::SCALE_RST, piea_pkg::K_RST);
        6: set_config('1, 32'hFFFF_FFFF, 16'($urandom()));
        default: set_config(64'd0, $urandom(), 16'($urandom()));
      endcase
      if (p == 0) begin
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd0, 0, 0, 0, 0, 0, 16384,
                                      32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd1, 40960, 0, -4096, 0, 0, 16384,
                                      32'd9));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd1, 40960, 0, 4096, 0, 0, 16384,
                                      32'd9));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd2, 0, 40960, 409600, 0, 0, 16384,
                                      32'd77));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd4, -8388608, -8388608, -8388608,
                                      -16384, -16384, -16384, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd4, 8388607, 8388607, 8388607,
                                      16384, 16384, 16384, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd5, 4096, 4096, 4096,
                                      16384, 16384, 16384, 32'd1000));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd1023, 8388607, -8388608, 100,
                                      16384, 0, 0, 32'd0));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd6, 409600, 0, 0, -16384, 0, 0,
                                      32'd5));
        pending_reqs.push_back(mk_req(piea_pkg::OP_READ, 10'd4, 0, 0, 0, 0, 0, 0, 32'd0));
        pending_reqs.push_back(mk_req(piea_pkg::OP_READ, 10'd1, 0, 0, 0, 0, 0, 0, 32'd0));
        pending_reqs.push_back(mk_req(piea_pkg::OP_CLEAR, 10'd7, 0, 0, 0, 0, 0, 0, 32'd0));
        pending_reqs.push_back(mk_req(piea_pkg::OP_READ, 10'd4, 0, 0, 0, 0, 0, 0, 32'd0));
        pending_reqs.push_back(mk_req(piea_pkg::OP_IMPACT, 10'd4, 81920, 0, 40960, 0, 0, 16384,
                                      32'd3));
      end
      for (int i = 0; i < 244; i++) pending_reqs.push_back(rand_req());
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
